[hw/rtl/gcb_pkg.sv]
// Shared constants, types and constant functions of the gamma curve generator.
package gcb_pkg;

	localparam int MAX_ENTRIES = 4096;
	localparam int IDX_W = 12;
	localparam int M_W = 17;
	localparam int LOG_W = 20;
	localparam int T_W = 27;
	localparam int ACC_W = 31;
	localparam int CF_W = 24;

	localparam logic [2:0] REG_BRIGHTNESS = 3'd0;
	localparam logic [2:0] REG_CONTRAST = 3'd1;
	localparam logic [2:0] REG_GAMMA = 3'd2;
	localparam logic [2:0] REG_MAX_VALUE = 3'd3;
	localparam logic [2:0] REG_TABLE_SIZE = 3'd4;

	typedef struct packed {
		logic err;
		logic zero_i;
		logic signed [7:0] bright;
		logic signed [7:0] contr;
		logic [9:0] gam;
		logic [15:0] maxv;
	} side_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] rem;
		logic [63:0] res;
		logic [63:0] bv;
		rem = v;
		res = '0;
		bv = 64'h4000_0000_0000_0000;
		for (int i = 0; i < 32; i++) begin
			if (rem >= res + bv) begin
				rem = rem - (res + bv);
				res = (res >> 1) + bv;
			end else begin
				res = res >> 1;
			end
			bv = bv >> 2;
		end
		return res;
	endfunction

	// 2^-(2^-k) in Q30, each a square root of the one before
	function automatic logic [29:0] root_const(input int k);
		logic [63:0] c;
		c = isqrt64(64'd1 << 59);
		for (int j = 1; j < k; j++) begin
			c = isqrt64(c << 30);
		end
		return c[29:0];
	endfunction

endpackage

[hw/rtl/gamma_contrast_brightness_curve.sv]
// Brightness, contrast and gamma curve generator: one lookup-table entry per input index.
// Takes one index per cycle unless the output stalls; the depth is set by the sixteen
// squaring steps of log2, the 27-stage exponent divider, the sixteen root multiplies of
// exp2 and stages for scaling, contrast and clamping. Indices at or beyond the table size
// return 0 with index_error set. Registers are written by the user, while no transaction
// is in flight, through cfg_we/cfg_addr/cfg_wdata; the block does not enforce this.
module gamma_contrast_brightness_curve #(
	parameter int VALUE_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [11:0] entry_index
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [((VALUE_BITS+8)/8)*8-1:0] m_axis_tdata,  // entry_value, then index_error
	input  logic cfg_we,
	input  logic [2:0] cfg_addr,
	input  logic [15:0] cfg_wdata
);
	import gcb_pkg::*;

	localparam int OUT_W = ((VALUE_BITS + 8) / 8) * 8;
	localparam int LAT = 67;
	localparam int SD_N = LAT - 1;
	localparam logic [15:0] VMASK = (VALUE_BITS >= 16) ? 16'hFFFF :
		16'((32'd1 << VALUE_BITS) - 32'd1);

	logic [7:0] bright_q;
	logic [7:0] contr_q;
	logic [9:0] gamma_q;
	logic [15:0] maxval_q;
	logic [12:0] tsize_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bright_q <= 8'd0;
			contr_q <= 8'd0;
			gamma_q <= 10'd100;
			maxval_q <= 16'd255;
			tsize_q <= 13'd256;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_BRIGHTNESS: bright_q <= cfg_wdata[7:0];
				REG_CONTRAST:   contr_q <= cfg_wdata[7:0];
				REG_GAMMA:      gamma_q <= cfg_wdata[9:0];
				REG_MAX_VALUE:  maxval_q <= cfg_wdata[15:0];
				REG_TABLE_SIZE: tsize_q <= cfg_wdata[12:0];
				default: ;
			endcase
		end
	end

	logic en;
	logic [LAT-1:0] vld_s;

	assign en = !vld_s[LAT-1] || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = vld_s[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LAT-2:0], s_axis_tvalid};
		end
	end

	// input stage: clip the configuration, normalise index and size for log2
	function automatic logic [3:0] msb13(input logic [12:0] v);
		logic [3:0] k;
		k = 4'd0;
		for (int b = 0; b < 13; b++) begin
			if (v[b]) k = 4'(b);
		end
		return k;
	endfunction

	logic [IDX_W-1:0] idx;
	logic [12:0] n_lim;
	logic [3:0] k_i;
	logic [3:0] k_n;
	logic [28:0] sh_i;
	logic [28:0] sh_n;
	side_t side_in;

	assign idx = s_axis_tdata[IDX_W-1:0];
	assign n_lim = (tsize_q > 13'(MAX_ENTRIES)) ? 13'(MAX_ENTRIES) : tsize_q;
	assign k_i = msb13({1'b0, idx});
	assign k_n = msb13(n_lim);
	assign sh_i = {17'd0, idx} << (5'd16 - {1'b0, k_i});
	assign sh_n = {16'd0, n_lim} << (5'd16 - {1'b0, k_n});

	always_comb begin
		side_in.err = {1'b0, idx} >= n_lim;
		side_in.zero_i = idx == '0;
		side_in.bright = $signed(bright_q);
		if ($signed(contr_q) > 8'sd99) side_in.contr = 8'sd99;
		else if ($signed(contr_q) < -8'sd99) side_in.contr = -8'sd99;
		else side_in.contr = $signed(contr_q);
		side_in.gam = (gamma_q == '0) ? 10'd1 : gamma_q;
		side_in.maxv = (maxval_q > VMASK) ? VMASK : maxval_q;
	end

	side_t sd_s [SD_N];

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s[0] <= side_in;
			for (int i = 1; i < SD_N; i++) begin
				sd_s[i] <= sd_s[i-1];
			end
		end
	end

	logic [M_W-1:0] mi_s1;
	logic [M_W-1:0] mn_s1;
	logic [LOG_W-1:0] ri_s1;
	logic [LOG_W-1:0] rn_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			mi_s1 <= sh_i[M_W-1:0];
			mn_s1 <= sh_n[M_W-1:0];
			ri_s1 <= {k_i, 16'd0};
			rn_s1 <= {k_n, 16'd0};
		end
	end

	logic [M_W-1:0] mi_l [16];
	logic [M_W-1:0] mn_l [16];
	logic [LOG_W-1:0] ri_l [16];
	logic [LOG_W-1:0] rn_l [16];

	for (genvar j = 0; j < 16; j++) begin : g_log
		if (j == 0) begin : g_first
			gcb_log2_stage #(.J(j)) u_stage (
				.clk(clk), .en(en),
				.mi(mi_s1), .mn(mn_s1), .ri(ri_s1), .rn(rn_s1),
				.mi_o(mi_l[j]), .mn_o(mn_l[j]), .ri_o(ri_l[j]), .rn_o(rn_l[j])
			);
		end else begin : g_next
			gcb_log2_stage #(.J(j)) u_stage (
				.clk(clk), .en(en),
				.mi(mi_l[j-1]), .mn(mn_l[j-1]), .ri(ri_l[j-1]), .rn(rn_l[j-1]),
				.mi_o(mi_l[j]), .mn_o(mn_l[j]), .ri_o(ri_l[j]), .rn_o(rn_l[j])
			);
		end
	end

	// exponent numerator: 100*(log2 n - log2 i) + g/2, rounded by the divider
	logic [LOG_W-1:0] d_log;
	logic [T_W-1:0] num_s18;

	assign d_log = (rn_l[15] > ri_l[15]) ? rn_l[15] - ri_l[15] : '0;

	always_ff @(posedge clk) begin
		if (en) begin
			num_s18 <= T_W'(d_log) * T_W'(7'd100) + T_W'(sd_s[16].gam >> 1);
		end
	end

	logic [T_W-1:0] t_div;

	gcb_div_pipe #(.NUM_W(T_W), .DEN_W(10)) u_div_t (
		.clk(clk), .en(en), .num(num_s18), .den(sd_s[17].gam), .quo(t_div)
	);

	// contrast factor, timed to land beside the contrast multiply
	logic [8:0] cden;
	logic [T_W-1:0] cq;
	logic [CF_W-1:0] cf;

	assign cden = 9'sd100 - {sd_s[36].contr[7], sd_s[36].contr};

	gcb_div_pipe #(.NUM_W(T_W), .DEN_W(8)) u_div_cf (
		.clk(clk), .en(en), .num(T_W'(24'd13107200)), .den(cden[7:0]), .quo(cq)
	);

	assign cf = CF_W'(cq - T_W'(32'd65536));

	logic [ACC_W-1:0] acc_p [16];
	logic [T_W-1:0] t_p [16];

	for (genvar k = 1; k <= 16; k++) begin : g_pow
		if (k == 1) begin : g_first
			gcb_pow_stage #(.K(k)) u_stage (
				.clk(clk), .en(en),
				.acc(ACC_W'(32'h4000_0000)), .t(t_div),
				.acc_o(acc_p[k-1]), .t_o(t_p[k-1])
			);
		end else begin : g_next
			gcb_pow_stage #(.K(k)) u_stage (
				.clk(clk), .en(en),
				.acc(acc_p[k-2]), .t(t_p[k-2]),
				.acc_o(acc_p[k-1]), .t_o(t_p[k-1])
			);
		end
	end

	logic [10:0] q_int;
	logic [ACC_W-1:0] p30_s62;

	assign q_int = t_p[15][T_W-1:16];

	always_ff @(posedge clk) begin
		if (en) begin
			if (sd_s[60].zero_i || q_int >= 11'd31) p30_s62 <= '0;
			else p30_s62 <= acc_p[15] >> q_int[4:0];
		end
	end

	logic [ACC_W+15:0] xprod;
	logic [31:0] x16_s63;

	assign xprod = p30_s62 * sd_s[61].maxv;

	always_ff @(posedge clk) begin
		if (en) begin
			x16_s63 <= xprod[45:14];
		end
	end

	logic [32:0] diff;
	logic [30:0] abs_s64;
	logic neg_s64;

	assign diff = {1'b0, x16_s63} - {2'b0, sd_s[62].maxv, 15'd0};

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s64 <= diff[32];
			abs_s64 <= diff[32] ? 31'(-diff) : diff[30:0];
		end
	end

	logic [54:0] mprod;
	logic [38:0] mag_s65;
	logic neg_s65;

	assign mprod = abs_s64 * cf;

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s65 <= mprod[54:16];
			neg_s65 <= neg_s64;
		end
	end

	logic signed [41:0] half42;
	logic signed [41:0] mag42;
	logic signed [41:0] b42;
	logic signed [41:0] v_s66;

	assign half42 = $signed({11'd0, sd_s[64].maxv, 15'd0});
	assign mag42 = neg_s65 ? -$signed({3'd0, mag_s65}) : $signed({3'd0, mag_s65});
	assign b42 = $signed({{17{sd_s[64].bright[7]}}, sd_s[64].bright, 17'd0});

	always_ff @(posedge clk) begin
		if (en) begin
			v_s66 <= half42 + mag42 + b42 + 42'sd32768;
		end
	end

	logic [25:0] v_int;
	logic [15:0] value_s67;
	logic err_s67;

	assign v_int = v_s66[41:16];

	// clamp to 0..max and zero the value of an out-of-table index
	always_ff @(posedge clk) begin
		if (en) begin
			err_s67 <= sd_s[65].err;
			if (sd_s[65].err || v_s66[41]) value_s67 <= '0;
			else if (v_int > {10'd0, sd_s[65].maxv}) value_s67 <= sd_s[65].maxv;
			else value_s67 <= v_int[15:0];
		end
	end

	assign m_axis_tdata = OUT_W'({err_s67, VALUE_BITS'(value_s67)});

endmodule

[hw/rtl/gcb_log2_stage.sv]
// One squaring step of the log2 fraction, for the index and the table size.
module gcb_log2_stage #(
	parameter int J = 0
) (
	input  logic clk,
	input  logic en,
	input  logic [gcb_pkg::M_W-1:0] mi,
	input  logic [gcb_pkg::M_W-1:0] mn,
	input  logic [gcb_pkg::LOG_W-1:0] ri,
	input  logic [gcb_pkg::LOG_W-1:0] rn,
	output logic [gcb_pkg::M_W-1:0] mi_o,
	output logic [gcb_pkg::M_W-1:0] mn_o,
	output logic [gcb_pkg::LOG_W-1:0] ri_o,
	output logic [gcb_pkg::LOG_W-1:0] rn_o
);
	import gcb_pkg::*;

	localparam int POS = 15 - J;

	logic [2*M_W-1:0] sq_i;
	logic [2*M_W-1:0] sq_n;
	logic [M_W:0] s_i;
	logic [M_W:0] s_n;

	assign sq_i = mi * mi;
	assign sq_n = mn * mn;
	assign s_i = sq_i[2*M_W-1:16];
	assign s_n = sq_n[2*M_W-1:16];

	always_ff @(posedge clk) begin
		if (en) begin
			mi_o <= s_i[M_W] ? s_i[M_W:1] : s_i[M_W-1:0];
			mn_o <= s_n[M_W] ? s_n[M_W:1] : s_n[M_W-1:0];
			ri_o <= ri | (LOG_W'(s_i[M_W]) << POS);
			rn_o <= rn | (LOG_W'(s_n[M_W]) << POS);
		end
	end

endmodule

[hw/rtl/gcb_div_pipe.sv]
// Pipelined restoring divider, one quotient bit per stage.
module gcb_div_pipe #(
	parameter int NUM_W = 27,
	parameter int DEN_W = 10
) (
	input  logic clk,
	input  logic en,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [NUM_W-1:0] quo
);
	logic [DEN_W-1:0] rem_s [NUM_W-1];
	logic [NUM_W-1:0] num_s [NUM_W-1];
	logic [DEN_W-1:0] den_s [NUM_W-1];
	logic [NUM_W-1:0] quo_s [NUM_W];

	for (genvar k = 0; k < NUM_W; k++) begin : g_stage
		logic [DEN_W-1:0] rem_p;
		logic [DEN_W-1:0] den_p;
		logic [NUM_W-1:0] num_p;
		logic [NUM_W-1:0] quo_p;
		logic [DEN_W:0] trial;
		logic take;

		if (k == 0) begin : g_first
			assign rem_p = '0;
			assign den_p = den;
			assign num_p = num;
			assign quo_p = '0;
		end else begin : g_next
			assign rem_p = rem_s[k-1];
			assign den_p = den_s[k-1];
			assign num_p = num_s[k-1];
			assign quo_p = quo_s[k-1];
		end

		assign trial = {rem_p, num_p[NUM_W-1]};
		assign take = trial >= {1'b0, den_p};

		always_ff @(posedge clk) begin
			if (en) begin
				quo_s[k] <= {quo_p[NUM_W-2:0], take};
			end
		end

		if (k < NUM_W - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= take ? DEN_W'(trial - {1'b0, den_p}) : trial[DEN_W-1:0];
					num_s[k] <= num_p << 1;
					den_s[k] <= den_p;
				end
			end
		end
	end

	assign quo = quo_s[NUM_W-1];

endmodule

[hw/rtl/gcb_pow_stage.sv]
// One step of 2^-f: multiply by a root constant when the fraction bit is set.
module gcb_pow_stage #(
	parameter int K = 1
) (
	input  logic clk,
	input  logic en,
	input  logic [gcb_pkg::ACC_W-1:0] acc,
	input  logic [gcb_pkg::T_W-1:0] t,
	output logic [gcb_pkg::ACC_W-1:0] acc_o,
	output logic [gcb_pkg::T_W-1:0] t_o
);
	import gcb_pkg::*;

	localparam int POS = 16 - K;
	localparam logic [29:0] ROOT = root_const(K);

	logic [ACC_W+29:0] prod;

	assign prod = acc * ROOT;

	always_ff @(posedge clk) begin
		if (en) begin
			acc_o <= t[POS] ? prod[ACC_W+29:30] : acc;
			t_o <= t;
		end
	end

endmodule

[sim/tb.sv]
// Self-checking bench for the gamma curve generator: computes the entry of each index sent and compares it.
module tb;
	import gcb_pkg::*;

	localparam int VB = 16;
	localparam int OUT_W = ((VB + 8) / 8) * 8;
	localparam int LATENCY = 67;

	typedef struct {
		logic [15:0] value;
		logic        err;
	} entry_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [15:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [OUT_W-1:0] m_axis_tdata;
	logic cfg_we;
	logic [2:0] cfg_addr;
	logic [15:0] cfg_wdata;

	gamma_contrast_brightness_curve #(.VALUE_BITS(VB)) uut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
	);

	// shadow copy of the registers
	logic [7:0]  sh_bright;
	logic [7:0]  sh_contr;
	logic [9:0]  sh_gamma;
	logic [15:0] sh_maxv;
	logic [12:0] sh_size;

	logic [11:0] index_q[$];
	entry_t      entry_q[$];
	int          send_idle;
	int          recv_idle;
	int          errors;
	bit          cfg_req;
	logic [2:0]  cfg_req_addr;
	logic [15:0] cfg_req_data;

	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] rem, res, bv;
		rem = v;
		res = '0;
		bv = 64'h4000_0000_0000_0000;
		while (bv > rem && bv != 0) bv = bv >> 2;
		while (bv != 0) begin
			if (rem >= res + bv) begin
				rem = rem - (res + bv);
				res = (res >> 1) + bv;
			end else begin
				res = res >> 1;
			end
			bv = bv >> 2;
		end
		return res;
	endfunction

	function automatic logic [63:0] log2_fix(input logic [63:0] v);
		int k;
		logic [63:0] m, r;
		k = 0;
		while (k < 63 && (v >> (k + 1)) != 0) k++;
		m = (k <= 16) ? (v << (16 - k)) : (v >> (k - 16));
		r = 64'(k) << 16;
		for (int j = 0; j < 16; j++) begin
			m = (m * m) >> 16;
			if (m >= (64'd2 << 16)) begin
				m = m >> 1;
				r[15 - j] = 1'b1;
			end
		end
		return r;
	endfunction

	function automatic logic [63:0] power_q30(input logic [63:0] i, n, g);
		logic [63:0] ln, li, d, t, q, f, acc, c;
		ln = log2_fix(n);
		li = log2_fix(i);
		d = (ln > li) ? ln - li : 0;
		t = (d * 100 + g / 2) / g;
		q = t >> 16;
		f = t & 64'hFFFF;
		acc = 64'd1 << 30;
		c = int_sqrt(64'd1 << 59);
		if (q >= 31) return 0;
		for (int k = 1; k <= 16; k++) begin
			if ((f >> (16 - k)) & 1) acc = (acc * c) >> 30;
			c = int_sqrt(c << 30);
		end
		return acc >> q;
	endfunction

	function automatic entry_t curve_entry(input logic [11:0] idx);
		entry_t e;
		longint unsigned n, maxv, g, p30, cf, mag;
		longint c, b, x16, half16, diff, v;
		n = sh_size;
		if (n > MAX_ENTRIES) n = MAX_ENTRIES;
		if (idx >= n) begin
			e.value = '0;
			e.err = 1'b1;
			return e;
		end
		maxv = sh_maxv;
		g = (sh_gamma == 0) ? 1 : sh_gamma;
		c = longint'($signed(sh_contr));
		b = longint'($signed(sh_bright));
		if (c > 99) c = 99;
		if (c < -99) c = -99;
		p30 = (idx == 0) ? 0 : power_q30(idx, n, g);
		cf = ((64'd200 << 16) / $unsigned(100 - c)) - 65536;
		x16 = longint'((p30 * maxv) >> 14);
		half16 = longint'(maxv << 15);
		diff = x16 - half16;
		mag = ($unsigned(diff < 0 ? -diff : diff) * cf) >> 16;
		v = half16 + (diff < 0 ? -longint'(mag) : longint'(mag)) + b * 131072 + 32768;
		e.err = 1'b0;
		if (v < 0) begin
			e.value = '0;
		end else begin
			v = v >>> 16;
			if (v > longint'(maxv)) v = maxv;
			e.value = v[15:0];
		end
		return e;
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// driver: writes a pending register, else offers the next index
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			cfg_we <= 1'b0;
			cfg_addr <= '0;
			cfg_wdata <= '0;
		end else begin
			cfg_we <= 1'b0;
			if (s_axis_tvalid && s_axis_tready) begin
				entry_q.push_back(curve_entry(s_axis_tdata[11:0]));
			end
			if (cfg_req) begin
				cfg_we <= 1'b1;
				cfg_addr <= cfg_req_addr;
				cfg_wdata <= cfg_req_data;
				case (cfg_req_addr)
					REG_BRIGHTNESS: sh_bright <= cfg_req_data[7:0];
					REG_CONTRAST: sh_contr <= cfg_req_data[7:0];
					REG_GAMMA: sh_gamma <= cfg_req_data[9:0];
					REG_MAX_VALUE: sh_maxv <= cfg_req_data;
					REG_TABLE_SIZE: sh_size <= cfg_req_data[12:0];
					default: ;
				endcase
				cfg_req <= 1'b0;
				s_axis_tvalid <= 1'b0;
			end else if (!s_axis_tvalid || s_axis_tready) begin
				if (index_q.size() != 0 && $urandom_range(99) >= send_idle) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {4'b0, index_q.pop_front()};
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		entry_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_idle);
			if (m_axis_tvalid && m_axis_tready) begin
				if (entry_q.size() == 0) begin
					$display("%0t: unexpected transaction %h", $time, m_axis_tdata);
					errors++;
				end else begin
					want = entry_q.pop_front();
					if (m_axis_tdata[15:0] !== want.value || m_axis_tdata[16] !== want.err) begin
						$display("%0t: expected value %0d err %0b, got value %0d err %0b",
							$time, want.value, want.err, m_axis_tdata[15:0], m_axis_tdata[16]);
						errors++;
					end
				end
			end
		end
	end

	task automatic write_reg(input logic [2:0] a, input logic [15:0] d);
		cfg_req_addr = a;
		cfg_req_data = d;
		cfg_req = 1'b1;
		@(posedge clk);
		while (cfg_req) @(posedge clk);
		@(posedge clk);
	endtask

	// hold until all indices are out and every entry is back
	task automatic drain();
		while (index_q.size() != 0 || s_axis_tvalid || entry_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	task automatic set_curve(input int br, ct, gm, mx, sz);
		write_reg(REG_BRIGHTNESS, 16'(br));
		write_reg(REG_CONTRAST, 16'(ct));
		write_reg(REG_GAMMA, 16'(gm));
		write_reg(REG_MAX_VALUE, 16'(mx));
		write_reg(REG_TABLE_SIZE, 16'(sz));
	endtask

	task automatic random_batch(input int count);
		int sz;
		sz = (sh_size > MAX_ENTRIES) ? MAX_ENTRIES : sh_size;
		for (int k = 0; k < count; k++) begin
			// mostly in-table indices, some beyond
			if ($urandom_range(9) < 8 && sz > 0) index_q.push_back(12'($urandom_range(sz - 1)));
			else index_q.push_back(12'($urandom));
		end
	endtask

	initial begin
		errors = 0;
		cfg_req = 1'b0;
		cfg_req_addr = '0;
		cfg_req_data = '0;
		send_idle = 15;
		recv_idle = 64;
		sh_bright = 8'd0;
		sh_contr = 8'd0;
		sh_gamma = 10'd100;
		sh_maxv = 16'd255;
		sh_size = 13'd256;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: defaults, edges of the index, out of table
		index_q.push_back(12'd0);
		index_q.push_back(12'd1);
		index_q.push_back(12'd128);
		index_q.push_back(12'd255);
		index_q.push_back(12'd256);
		index_q.push_back(12'd4095);
		index_q.push_back(12'd2730);
		index_q.push_back(12'd1365);
		drain();
		// extremes and odd codes: saturated contrast, gamma zero, zero max, tiny tables
		set_curve(-100, 99, 1, 65535, 4096);
		index_q.push_back(12'd0);
		index_q.push_back(12'd1);
		index_q.push_back(12'd4095);
		index_q.push_back(12'd2048);
		drain();
		set_curve(127, -128, 0, 0, 8191);
		index_q.push_back(12'd0);
		index_q.push_back(12'd4095);
		index_q.push_back(12'd7);
		drain();
		set_curve(-128, 127, 1023, 1, 1);
		index_q.push_back(12'd0);
		index_q.push_back(12'd1);
		drain();
		set_curve(100, -99, 1000, 65535, 0);
		write_reg(3'd7, 16'hFFFF);
		write_reg(3'd5, 16'h1234);
		index_q.push_back(12'd0);
		drain();
		set_curve(0, 0, 100, 255, 2);
		index_q.push_back(12'd0);
		index_q.push_back(12'd1);
		index_q.push_back(12'd2);
		drain();

		// random settings, three idle profiles
		for (int ph = 0; ph < 24; ph++) begin
			if (ph == 8) begin
				send_idle = 64;
				recv_idle = 15;
			end
			if (ph == 16) begin
				send_idle = 0;
				recv_idle = 0;
			end
			set_curve($urandom_range(8) == 0 ? $urandom_range(255) : $urandom_range(200) - 100,
				$urandom_range(8) == 0 ? $urandom_range(255) : $urandom_range(198) - 99,
				$urandom_range(9) == 0 ? $urandom_range(1023) : $urandom_range(1000, 1),
				$urandom_range(3) == 0 ? $urandom_range(65535) : $urandom_range(1023),
				$urandom_range(9) == 0 ? $urandom_range(8191) : $urandom_range(4096, 2));
			random_batch(80);
			drain();
		end

		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

[sim.f]
hw/rtl/gcb_pkg.sv
hw/rtl/gcb_log2_stage.sv
hw/rtl/gcb_div_pipe.sv
hw/rtl/gcb_pow_stage.sv
hw/rtl/gamma_contrast_brightness_curve.sv
sim/tb.sv
